[sv/wlac_pkg.sv]
// Shared types and constants for the water level alarm controller.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package wlac_pkg;

    localparam int DIST_W     = 12;
    localparam int POT_W      = 10;
    localparam int TIME_W     = 32;
    localparam int BLINK_W    = 16;
    localparam int ANGLE_W    = 8;
    localparam int LEVEL_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Serial divider: dividend holds |distance difference| * 180 < 2^20,
    // divisor holds a 12-bit span or the potentiometer span.
    localparam int DIV_W     = 20;
    localparam int DVS_W     = 12;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
    localparam logic [POT_W-1:0]   POT_LOW   = 10'd10;
    localparam logic [DVS_W-1:0]   POT_SPAN  = 12'd990;

    localparam logic [DIST_W-1:0]  RST_NORMAL_THR   = 12'd100;
    localparam logic [DIST_W-1:0]  RST_PREALARM_THR = 12'd50;
    localparam logic [DIST_W-1:0]  RST_MAX_LEVEL    = 12'd20;
    localparam logic [BLINK_W-1:0] RST_BLINK_MS     = 16'd500;

    typedef enum logic [LEVEL_W-1:0] {
        LVL_NORMAL = 2'd0,
        LVL_PRE    = 2'd1,
        LVL_ALARM  = 2'd2
    } t_level;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORMAL_THR   = 2'd0,
        REG_PREALARM_THR = 2'd1,
        REG_MAX_LEVEL    = 2'd2,
        REG_BLINK_MS     = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

[sv/wlac_div.sv]
// Bit-serial restoring divider for the valve angle, one quotient bit a cycle.
// Depends on wlac_pkg for operand widths.
`default_nettype none

module wlac_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [wlac_pkg::DIV_W-1:0]   i_dividend,
    input  wire logic [wlac_pkg::DVS_W-1:0]   i_divisor,
    output logic                              o_done,
    output logic [wlac_pkg::DIV_W-1:0]        o_quotient
);
    import wlac_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [DIV_W-1:0]     r_quo;

    logic [DVS_W:0] w_trial;
    logic [DVS_W:0] w_diff;
    logic           w_ge;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

[sv/water_level_alarm_controller.sv]
// Top level of the water level alarm controller: config registers, control
// sequencer, state and result register. Depends on wlac_pkg and wlac_div.
`default_nettype none

// Each input beat is either a sonar sample (i_action = 0) or a manual button
// press (i_action = 1) and yields exactly one result beat. A sample is classed
// as normal, pre-alarm or alarm against the two thresholds and updates the
// LEDs, lighting permission and valve. The block takes one beat at a time.
// A button press, or a sample that needs no division, passes the evaluate
// and emit states; result valid rises and the input is ready again when the
// result register loads, which waits while an earlier result is not taken.
// An alarm sample whose valve angle needs a division also runs the 20-step
// bit-serial divider between the evaluate and emit states. The result sits
// in an output register, so the next beat is accepted while a result still
// waits. Configuration writes land at once and must only be issued while idle.
module water_level_alarm_controller (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [wlac_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [wlac_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_action,
    input  wire logic [wlac_pkg::DIST_W-1:0]      i_distance_cm,
    input  wire logic [wlac_pkg::POT_W-1:0]       i_pot_value,
    input  wire logic [wlac_pkg::TIME_W-1:0]      i_now_ms,
    // result channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [wlac_pkg::LEVEL_W-1:0]          o_level_state,
    output logic                                  o_green_led,
    output logic                                  o_red_led,
    output logic [wlac_pkg::ANGLE_W-1:0]          o_valve_angle,
    output logic                                  o_light_enable,
    output logic                                  o_backlight,
    output logic                                  o_manual_active
);
    import wlac_pkg::*;

    // configuration
    logic [DIST_W-1:0]  r_normal_thr;
    logic [DIST_W-1:0]  r_prealarm_thr;
    logic [DIST_W-1:0]  r_max_level;
    logic [BLINK_W-1:0] r_blink_ms;

    // sequencer
    t_state r_state;
    t_state n_state;

    // captured input beat
    logic              r_action;
    logic [DIST_W-1:0] r_dist;
    logic [POT_W-1:0]  r_pot;
    logic [TIME_W-1:0] r_now;

    // controller state
    t_level             r_prev_level;
    logic               r_manual;
    logic               r_red;
    logic [TIME_W-1:0]  r_last_toggle;
    logic [ANGLE_W-1:0] r_valve;
    logic               r_lights;

    // result register
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_out_level;
    logic               r_out_green;
    logic               r_out_red;
    logic [ANGLE_W-1:0] r_out_angle;
    logic               r_out_light;
    logic               r_out_back;
    logic               r_out_manual;

    // evaluation datapath
    t_level             w_level;
    logic               w_leave;
    logic               w_enter;
    logic               w_manual_eval;
    logic [TIME_W-1:0]  w_elapsed;
    logic               w_blink_due;
    logic [DIST_W:0]    w_den;
    logic [DIST_W:0]    w_num;
    logic [DIST_W:0]    w_den_neg;
    logic [DIST_W:0]    w_num_neg;
    logic [DIST_W-1:0]  w_den_mag;
    logic [DIST_W-1:0]  w_num_mag;
    logic               w_pot_pos;
    logic [POT_W-1:0]   w_pot_off;
    logic               w_fast;
    logic [ANGLE_W-1:0] w_fast_angle;
    logic [DIV_W-1:0]   w_dividend;
    logic [DVS_W-1:0]   w_divisor;
    logic               w_div_start;
    logic               w_div_done;
    logic [DIV_W-1:0]   w_quotient;
    logic [ANGLE_W-1:0] w_div_angle;
    logic               w_out_free;
    logic               w_in_beat;

    assign w_in_beat  = i_in_valid & o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_thr   <= RST_NORMAL_THR;
            r_prealarm_thr <= RST_PREALARM_THR;
            r_max_level    <= RST_MAX_LEVEL;
            r_blink_ms     <= RST_BLINK_MS;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_NORMAL_THR:   r_normal_thr   <= i_cfg_data[DIST_W-1:0];
                REG_PREALARM_THR: r_prealarm_thr <= i_cfg_data[DIST_W-1:0];
                REG_MAX_LEVEL:    r_max_level    <= i_cfg_data[DIST_W-1:0];
                REG_BLINK_MS:     r_blink_ms     <= i_cfg_data[BLINK_W-1:0];
                default:          ;
            endcase
        end
    end

    // Class the sample against the thresholds.
    always_comb begin
        priority if (r_dist > r_normal_thr) begin
            w_level = LVL_NORMAL;
        end else if (r_dist > r_prealarm_thr) begin
            w_level = LVL_PRE;
        end else begin
            w_level = LVL_ALARM;
        end
    end

    assign w_leave       = (r_prev_level == LVL_ALARM) && (w_level != LVL_ALARM);
    assign w_enter       = (r_prev_level != LVL_ALARM) && (w_level == LVL_ALARM);
    assign w_manual_eval = (w_leave || w_enter) ? 1'b0 : r_manual;

    // Elapsed time wraps modulo 2^32.
    assign w_elapsed   = r_now - r_last_toggle;
    assign w_blink_due = (w_elapsed >= {{(TIME_W-BLINK_W){1'b0}}, r_blink_ms});

    // Signed spans of the distance mapping, split into sign and magnitude.
    assign w_den     = {1'b0, r_max_level} - {1'b0, r_prealarm_thr};
    assign w_num     = {1'b0, r_dist} - {1'b0, r_prealarm_thr};
    assign w_den_neg = -w_den;
    assign w_num_neg = -w_num;
    assign w_den_mag = w_den[DIST_W] ? w_den_neg[DIST_W-1:0] : w_den[DIST_W-1:0];
    assign w_num_mag = w_num[DIST_W] ? w_num_neg[DIST_W-1:0] : w_num[DIST_W-1:0];

    assign w_pot_pos = (r_pot > POT_LOW);
    assign w_pot_off = r_pot - POT_LOW;

    // Resolve the angle without dividing where sign or a zero span settles it:
    // a non-positive quotient clamps to zero, equal bounds open fully.
    always_comb begin
        w_fast       = 1'b0;
        w_fast_angle = '0;
        if (w_manual_eval) begin
            w_fast = !w_pot_pos;
        end else if (w_den == '0) begin
            w_fast       = 1'b1;
            w_fast_angle = ANGLE_MAX;
        end else if ((w_num == '0) || (w_num[DIST_W] != w_den[DIST_W])) begin
            w_fast = 1'b1;
        end
    end

    always_comb begin
        if (w_manual_eval) begin
            w_dividend = DIV_W'({{(DIV_W-POT_W){1'b0}}, w_pot_off} * DIV_W'(ANGLE_MAX));
            w_divisor  = POT_SPAN;
        end else begin
            w_dividend = DIV_W'({{(DIV_W-DIST_W){1'b0}}, w_num_mag} * DIV_W'(ANGLE_MAX));
            w_divisor  = w_den_mag;
        end
    end

    assign w_div_start = (r_state == ST_EVAL) && !r_action &&
                         (w_level == LVL_ALARM) && !w_fast;

    wlac_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Saturate the quotient to the servo range.
    assign w_div_angle = (w_quotient > DIV_W'(ANGLE_MAX)) ? ANGLE_MAX
                                                          : w_quotient[ANGLE_W-1:0];

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = w_div_start ? ST_DIV : ST_EMIT;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Capture the input beat.
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_action <= i_action;
            r_dist   <= i_distance_cm;
            r_pot    <= i_pot_value;
            r_now    <= i_now_ms;
        end
    end

    // Controller state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level  <= LVL_NORMAL;
            r_manual      <= 1'b0;
            r_red         <= 1'b0;
            r_last_toggle <= '0;
            r_valve       <= '0;
            r_lights      <= 1'b1;
        end else if (r_state == ST_EVAL) begin
            if (r_action) begin
                r_manual <= !r_manual;
            end else begin
                r_prev_level <= w_level;
                r_manual     <= w_manual_eval;
                if (w_leave) begin
                    r_lights <= 1'b1;
                    r_valve  <= '0;
                end
                unique case (w_level)
                    LVL_NORMAL: r_red <= 1'b0;
                    LVL_PRE: begin
                        if (w_blink_due) begin
                            r_red         <= !r_red;
                            r_last_toggle <= r_now;
                        end
                    end
                    LVL_ALARM: begin
                        r_lights <= 1'b0;
                        r_red    <= 1'b1;
                        if (w_fast) begin
                            r_valve <= w_fast_angle;
                        end
                    end
                    default: ;
                endcase
            end
        end else if ((r_state == ST_DIV) && w_div_done) begin
            r_valve <= w_div_angle;
        end
    end

    // Result register: load the held state, drop valid once the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_EMIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && w_out_free) begin
            r_out_level  <= r_prev_level;
            r_out_green  <= (r_prev_level != LVL_ALARM);
            r_out_red    <= r_red;
            r_out_angle  <= r_valve;
            r_out_light  <= r_lights;
            r_out_back   <= (r_prev_level != LVL_NORMAL);
            r_out_manual <= r_manual;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_level_state   = r_out_level;
    assign o_green_led     = r_out_green;
    assign o_red_led       = r_out_red;
    assign o_valve_angle   = r_out_angle;
    assign o_light_enable  = r_out_light;
    assign o_backlight     = r_out_back;
    assign o_manual_active = r_out_manual;

endmodule

`default_nettype wire

[sim/tb.sv]
// Testbench for water_level_alarm_controller: directed and random beats checked
// against an in-bench model of the alarm logic. Depends on wlac_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import wlac_pkg::*;

    // Angle scaling used by the panel model.
    localparam int  DEG_FULL    = 180;
    localparam int  POT_ZERO    = 10;
    localparam int  POT_RANGE   = 990;
    localparam int  CYCLE_LIMIT = 200000;
    // Extra idle margin on top of the longest result latency.
    localparam int  SETTLE      = 40;

    typedef struct {
        t_level               level;
        logic                 green;
        logic                 red;
        logic [ANGLE_W-1:0]   valve;
        logic                 light;
        logic                 backl;
        logic                 manual;
    } t_panel;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_action = 1'b0;
    logic [DIST_W-1:0]     i_distance_cm = '0;
    logic [POT_W-1:0]      i_pot_value = '0;
    logic [TIME_W-1:0]     i_now_ms = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [LEVEL_W-1:0]    o_level_state;
    logic                  o_green_led;
    logic                  o_red_led;
    logic [ANGLE_W-1:0]    o_valve_angle;
    logic                  o_light_enable;
    logic                  o_backlight;
    logic                  o_manual_active;

    water_level_alarm_controller uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_distance_cm   (i_distance_cm),
        .i_pot_value     (i_pot_value),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_level_state   (o_level_state),
        .o_green_led     (o_green_led),
        .o_red_led       (o_red_led),
        .o_valve_angle   (o_valve_angle),
        .o_light_enable  (o_light_enable),
        .o_backlight     (o_backlight),
        .o_manual_active (o_manual_active)
    );

    always #2 i_clk = ~i_clk;

    // Model copy of the configuration registers.
    logic [DIST_W-1:0]  cfg_normal;
    logic [DIST_W-1:0]  cfg_prealarm;
    logic [DIST_W-1:0]  cfg_full_dist;
    logic [BLINK_W-1:0] cfg_blink;

    // Model copy of the controller state.
    t_level             held_level;
    logic               manual_on;
    logic               red_on;
    logic [TIME_W-1:0]  blink_mark_ms;
    logic [ANGLE_W-1:0] valve_deg;
    logic               lights_on;

    t_panel             panel_due[$];     // panels predicted, not yet seen
    logic [TIME_W-1:0]  wall_ms = '0;     // running time stamp for samples
    int                 errors = 0;
    int                 panels_seen = 0;
    int                 cycle_cnt = 0;
    bit                 in_gaps_on = 1'b0;
    bit                 sink_gaps_on = 1'b0;
    int                 sink_hold_len = 0;
    int                 sink_left = 0;

    task automatic flag_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $realtime, panels_seen, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    function automatic logic [ANGLE_W-1:0] clamp_deg(input longint a);
        if (a < 0)
            return '0;
        if (a > DEG_FULL)
            return ANGLE_W'(DEG_FULL);
        return ANGLE_W'(a);
    endfunction

    // Advance the model by one accepted beat and queue the panel it yields.
    task automatic predict_panel(input logic act, input logic [DIST_W-1:0] dist_cm,
                                 input logic [POT_W-1:0] pot,
                                 input logic [TIME_W-1:0] now);
        t_level            lvl;
        t_panel            p;
        logic [TIME_W-1:0] elapsed;
        longint            num;
        longint            den;
        if (act) begin
            manual_on = ~manual_on;
        end else begin
            if (dist_cm > cfg_normal)
                lvl = LVL_NORMAL;
            else if (dist_cm > cfg_prealarm)
                lvl = LVL_PRE;
            else
                lvl = LVL_ALARM;
            // Leaving alarm restores lights and closes the valve.
            if (held_level == LVL_ALARM && lvl != LVL_ALARM) begin
                manual_on = 1'b0;
                lights_on = 1'b1;
                valve_deg = '0;
            end
            if (held_level != LVL_ALARM && lvl == LVL_ALARM)
                manual_on = 1'b0;
            held_level = lvl;
            case (lvl)
                LVL_NORMAL: begin
                    red_on = 1'b0;
                end
                LVL_PRE: begin
                    elapsed = now - blink_mark_ms;
                    if (elapsed >= {16'd0, cfg_blink}) begin
                        red_on = ~red_on;
                        blink_mark_ms = now;
                    end
                end
                default: begin
                    lights_on = 1'b0;
                    red_on = 1'b1;
                    if (manual_on) begin
                        num = (longint'(pot) - POT_ZERO) * DEG_FULL;
                        valve_deg = clamp_deg(num / POT_RANGE);
                    end else begin
                        den = longint'(cfg_full_dist) - longint'(cfg_prealarm);
                        num = (longint'(dist_cm) - longint'(cfg_prealarm)) * DEG_FULL;
                        valve_deg = (den == 0) ? ANGLE_W'(DEG_FULL) : clamp_deg(num / den);
                    end
                end
            endcase
        end
        p.level  = held_level;
        p.green  = (held_level != LVL_ALARM);
        p.red    = red_on;
        p.valve  = valve_deg;
        p.light  = lights_on;
        p.backl  = (held_level != LVL_NORMAL);
        p.manual = manual_on;
        panel_due.push_back(p);
    endtask

    // Offer one beat, sometimes after an idle gap with valid low. Returns right
    // after the accepting edge with valid still high.
    task automatic send_beat(input logic act, input logic [DIST_W-1:0] dist_cm,
                             input logic [POT_W-1:0] pot,
                             input logic [TIME_W-1:0] now);
        int gap;
        if (in_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_distance_cm <= dist_cm;
        i_pot_value   <= pot;
        i_now_ms      <= now;
        do @(posedge i_clk); while (!o_in_ready);
        predict_panel(act, dist_cm, pot, now);
    endtask

    task automatic press_button();
        send_beat(1'b1, DIST_W'($urandom), POT_W'($urandom), $urandom);
    endtask

    // Drop valid, then hold off until every queued panel has been seen.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (panel_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_NORMAL_THR:   cfg_normal    = data[DIST_W-1:0];
            REG_PREALARM_THR: cfg_prealarm  = data[DIST_W-1:0];
            REG_MAX_LEVEL:    cfg_full_dist = data[DIST_W-1:0];
            default:          cfg_blink     = data;
        endcase
    endtask

    // Write all four registers; junk in the top nibble of the 12-bit ones
    // must be dropped by the block.
    task automatic write_all(input int normal, input int prealarm, input int full,
                             input int blink);
        write_reg(REG_NORMAL_THR,   {4'($urandom), 12'(normal)});
        write_reg(REG_PREALARM_THR, {4'($urandom), 12'(prealarm)});
        write_reg(REG_MAX_LEVEL,    {4'($urandom), 12'(full)});
        write_reg(REG_BLINK_MS,     16'(blink));
    endtask

    // Distance that mostly lands near a class boundary or the mapping span.
    function automatic logic [DIST_W-1:0] pick_depth();
        int d;
        int lo;
        int hi;
        lo = (cfg_full_dist < cfg_prealarm) ? int'(cfg_full_dist) : int'(cfg_prealarm);
        hi = (cfg_full_dist < cfg_prealarm) ? int'(cfg_prealarm) : int'(cfg_full_dist);
        case ($urandom_range(0, 9))
            0, 1, 2: d = int'(cfg_normal) + int'($urandom_range(0, 8)) - 4;
            3, 4, 5: d = int'(cfg_prealarm) + int'($urandom_range(0, 8)) - 4;
            6, 7:    d = int'($urandom_range(lo, hi));
            8:       d = int'(cfg_full_dist) + int'($urandom_range(0, 8)) - 4;
            default: d = int'($urandom_range(0, 4095));
        endcase
        if (d < 0)
            d = 0;
        if (d > 4095)
            d = 4095;
        return DIST_W'(d);
    endfunction

    task automatic send_sample(input int dist_cm, input int pot,
                               input logic [TIME_W-1:0] now);
        send_beat(1'b0, DIST_W'(dist_cm), POT_W'(pot), now);
    endtask

    // Walk through every class, boundary, blink case and angle clamp at the
    // reset configuration.
    task automatic test_reset_defaults();
        send_sample(4095, 0, 0);
        press_button();
        press_button();
        send_sample(101, 0, 0);
        send_sample(100, 0, 0);                 // pre-alarm, no time passed
        send_sample(51, 0, 499);
        send_sample(75, 0, 500);                // blink period reached
        press_button();                         // manual outside alarm
        send_sample(60, 1023, 999);
        send_sample(60, 1023, 1000);
        send_sample(50, 1023, 1001);            // enter alarm, drop manual
        send_sample(35, 0, 1002);
        send_sample(20, 0, 1003);
        send_sample(0, 0, 1004);                // mapped angle over full scale
        press_button();
        send_sample(30, 0, 1005);
        send_sample(30, 9, 1006);               // pot below the low stop
        send_sample(30, 10, 1007);
        send_sample(30, 1000, 1008);
        send_sample(30, 1023, 1009);            // pot over full scale
        send_sample(30, 505, 1010);
        send_sample(4095, 0, 1011);             // leave alarm
        send_sample(75, 0, 32'hFFFF_FF00);
        send_sample(75, 0, 32'h0000_0010);      // time stamp wrapped, short gap
        send_sample(75, 0, 32'h0000_01F4);
        wait_drained();
    endtask

    // Registers at their extremes: equal mapping bounds, zero and full blink.
    task automatic test_config_extremes();
        write_all(4095, 0, 0, 0);
        send_sample(4095, 0, 7);
        send_sample(1, 0, 7);                   // zero period toggles each time
        send_sample(0, 0, 7);                   // equal bounds open the valve
        press_button();
        send_sample(0, 1023, 8);
        send_sample(2048, 0, 9);
        wait_drained();

        write_all(4095, 4095, 0, 65535);
        send_sample(0, 0, 10);
        send_sample(4095, 0, 11);
        send_sample(2048, 0, 12);
        wait_drained();

        write_all(4095, 0, 4095, 65535);
        send_sample(100, 0, 32'hFFFF_FFFF);
        send_sample(200, 0, 32'h0000_FFFD);     // one short of the period
        send_sample(300, 0, 32'h0000_FFFE);
        send_sample(0, 0, 32'h0001_0000);
        press_button();
        send_sample(0, 512, 32'h0001_0001);
        wait_drained();

        write_all(0, 0, 0, 1);
        send_sample(0, 0, 20);
        send_sample(1, 0, 21);
        wait_drained();
    endtask

    // Stall the result side for a long stretch while beats keep coming, so
    // the output register fills and the input side stalls.
    task automatic test_backpressure();
        write_all(300, 150, 30, 40);
        in_gaps_on   = 1'b0;
        sink_gaps_on = 1'b0;
        sink_hold_len = 150;
        repeat (24) begin
            wall_ms += $urandom_range(0, 60);
            if ($urandom_range(0, 7) == 0)
                press_button();
            else
                send_beat(1'b0, DIST_W'($urandom_range(0, 400)), POT_W'($urandom), wall_ms);
        end
        wait_drained();
    endtask

    // Phases of random configuration with mostly well-formed sample streams:
    // distances near the boundaries and time stamps that move forward.
    task automatic test_random_traffic(input int phases, input int per_phase);
        int normal;
        int prealarm;
        int full;
        int blink;
        for (int ph = 0; ph < phases; ph++) begin
            normal   = $urandom_range(0, 4095);
            prealarm = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                   : $urandom_range(0, normal);
            case ($urandom_range(0, 5))
                0:       full = prealarm;
                1:       full = $urandom_range(prealarm, 4095);
                default: full = $urandom_range(0, prealarm);
            endcase
            case ($urandom_range(0, 5))
                0:       blink = 0;
                1:       blink = 65535;
                default: blink = $urandom_range(1, 1500);
            endcase
            write_all(normal, prealarm, full, blink);
            // Keep the final phase free of idling on both sides.
            in_gaps_on   = (ph != phases - 1) && ($urandom_range(0, 3) != 0);
            sink_gaps_on = (ph != phases - 1) && ($urandom_range(0, 3) != 0);
            repeat (per_phase) begin
                if ($urandom_range(0, 19) == 0)
                    wall_ms = $urandom;
                else
                    wall_ms += $urandom_range(0, 2 * int'(cfg_blink) + 2);
                if ($urandom_range(0, 7) == 0)
                    press_button();
                else
                    send_beat(1'b0, pick_depth(), POT_W'($urandom), wall_ms);
            end
            wait_drained();
        end
    endtask

    // Result side: ready with random stall bursts, or a long hold on request.
    always @(negedge i_clk) begin
        if (sink_hold_len != 0) begin
            sink_left = sink_hold_len;
            sink_hold_len = 0;
        end
        if (sink_left != 0) begin
            i_out_ready <= 1'b0;
            sink_left--;
        end else if (sink_gaps_on && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            sink_left = $urandom_range(0, 2);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare every accepted result beat with the oldest predicted panel.
    always @(posedge i_clk) begin
        t_panel want;
        if (o_out_valid && i_out_ready) begin
            if (panel_due.size() == 0) begin
                flag_mismatch("result beat with no prediction pending");
            end else begin
                want = panel_due.pop_front();
                check_field("level_state",   o_level_state,   want.level);
                check_field("green_led",     o_green_led,     want.green);
                check_field("red_led",       o_red_led,       want.red);
                check_field("valve_angle",   o_valve_angle,   want.valve);
                check_field("light_enable",  o_light_enable,  want.light);
                check_field("backlight",     o_backlight,     want.backl);
                check_field("manual_active", o_manual_active, want.manual);
            end
            panels_seen++;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_cnt, panel_due.size());
            $display("** water_level_alarm_controller: FAILED **");
            $finish;
        end
    end

    initial begin
        cfg_normal    = RST_NORMAL_THR;
        cfg_prealarm  = RST_PREALARM_THR;
        cfg_full_dist = RST_MAX_LEVEL;
        cfg_blink     = RST_BLINK_MS;
        held_level    = LVL_NORMAL;
        manual_on     = 1'b0;
        red_on        = 1'b0;
        blink_mark_ms = '0;
        valve_deg     = '0;
        lights_on     = 1'b1;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_reset_defaults();
        test_config_extremes();
        test_backpressure();
        test_random_traffic(5, 90);

        wait_drained();
        if (errors == 0)
            $display("** water_level_alarm_controller: PASSED **");
        else
            $display("** water_level_alarm_controller: FAILED **");
        $finish;
    end

endmodule

[files.f]
sv/wlac_pkg.sv
sv/wlac_div.sv
sv/water_level_alarm_controller.sv
sim/tb.sv
